[rtl/rmst_pkg.sv]
// Shared types, widths and constants of the range-minimum segment tree.
// Used by the channel interfaces, the controller, the top level and the checker.
package rmst_pkg;

  localparam int MaxLeavesDefault = 1024;
  localparam int ValueW  = 32;
  localparam int CountW  = 11;
  localparam int IndexW  = 10;
  localparam int StatusW = 2;

  localparam logic signed [ValueW-1:0] EmptyMin = 32'sh7FFF_FFFF;

  typedef enum logic {
    ActUpdate = 1'b0,
    ActQuery  = 1'b1
  } action_e;

  typedef enum logic [StatusW-1:0] {
    StUpdDone    = 2'd0,
    StQryOk      = 2'd1,
    StOutOfRange = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPD,
    ST_QRY,
    ST_PUT
  } ctrl_state_e;

  typedef struct packed {
    status_e                   status;
    logic signed [ValueW-1:0]  value;
  } res_t;

  function automatic logic signed [ValueW-1:0] min_s(logic signed [ValueW-1:0] a,
                                                     logic signed [ValueW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

[rtl/rmst_in_if.sv]
// Input channel of the range-minimum segment tree: valid/ready plus one item.
// Depends on rmst_pkg for field widths.
interface rmst_in_if;
  logic                                valid;
  logic                                ready;
  logic                                action;
  logic [rmst_pkg::IndexW-1:0]         leaf_index;
  logic signed [rmst_pkg::ValueW-1:0]  new_value;
  logic [rmst_pkg::CountW-1:0]         range_start;
  logic [rmst_pkg::CountW-1:0]         range_end;

  modport source(output valid, action, leaf_index, new_value, range_start, range_end,
                 input ready);
  modport sink(input valid, action, leaf_index, new_value, range_start, range_end,
               output ready);
endinterface

[rtl/rmst_out_if.sv]
// Result channel of the range-minimum segment tree: valid/ready plus one result.
// Depends on rmst_pkg for field widths.
interface rmst_out_if;
  logic                                valid;
  logic                                ready;
  logic [rmst_pkg::StatusW-1:0]        status;
  logic signed [rmst_pkg::ValueW-1:0]  range_min;

  modport source(output valid, status, range_min, input ready);
  modport sink(input valid, status, range_min, output ready);
endinterface

[rtl/rmst_ram.sv]
// Node store of the segment tree: one write port, one read port, registered read data.
// Depends on rmst_pkg for the value width.
module rmst_ram #(
  parameter int Depth = 2 * rmst_pkg::MaxLeavesDefault,
  parameter int AddrW = $clog2(Depth)
) (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic [AddrW-1:0]                   waddr_i,
  input  logic signed [rmst_pkg::ValueW-1:0] wdata_i,
  input  logic                               re_i,
  input  logic [AddrW-1:0]                   raddr_i,
  output logic signed [rmst_pkg::ValueW-1:0] rdata_o
);

  logic signed [rmst_pkg::ValueW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[rtl/rmst_ctrl.sv]
// Sequencer of the segment tree: clearing sweep, leaf update with ancestor
// recompute, and range-minimum walk over the node store. Depends on rmst_pkg.
module rmst_ctrl #(
  parameter int MAX_LEAVES = rmst_pkg::MaxLeavesDefault,
  parameter int AW = $clog2(2 * MAX_LEAVES)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [rmst_pkg::CountW-1:0]        leaf_count_i,
  input  logic                               clear_i,
  rmst_in_if.sink                            in_i,
  output logic                               res_valid_o,
  input  logic                               res_ready_i,
  output rmst_pkg::res_t                     res_o,
  output logic                               mem_we_o,
  output logic [AW-1:0]                      mem_waddr_o,
  output logic signed [rmst_pkg::ValueW-1:0] mem_wdata_o,
  output logic                               mem_re_o,
  output logic [AW-1:0]                      mem_raddr_o,
  input  logic signed [rmst_pkg::ValueW-1:0] mem_rdata_i
);

  localparam int IW = AW + 1;
  localparam int SW = (IW > rmst_pkg::CountW + 1) ? IW : rmst_pkg::CountW + 1;
  localparam logic [AW-1:0] LastAddr = AW'(2 * MAX_LEAVES - 1);
  localparam logic [AW-1:0] RootAddr = AW'(1);

  rmst_pkg::ctrl_state_e state_q, state_d;
  logic [AW-1:0]          clr_q, clr_d;
  logic                   pend_q, pend_d;
  logic [AW-1:0]          k_q, k_d;
  logic [IW-1:0]          l_q, l_d, r_q, r_d;
  logic signed [rmst_pkg::ValueW-1:0] acc_q, acc_d, cur_q, cur_d;
  rmst_pkg::status_e      sts_q, sts_d;

  logic [SW-1:0]          n_ext, k_sum, l_sum, r_sum;
  logic [AW-1:0]          parent, k_sib, parent_sib;
  logic [IW-1:0]          l_inc, r_dec;
  logic signed [rmst_pkg::ValueW-1:0] upd_min, acc_fold;

  assign n_ext      = SW'(leaf_count_i);
  assign k_sum      = SW'(in_i.leaf_index) + n_ext;
  assign l_sum      = SW'(in_i.range_start) + n_ext;
  assign r_sum      = SW'(in_i.range_end) + n_ext;
  assign parent     = k_q >> 1;
  assign k_sib      = {k_q[AW-1:1], ~k_q[0]};
  assign parent_sib = {parent[AW-1:1], ~parent[0]};
  assign l_inc      = l_q + IW'(1);
  assign r_dec      = r_q - IW'(1);
  assign upd_min    = rmst_pkg::min_s(cur_q, mem_rdata_i);
  assign acc_fold   = pend_q ? rmst_pkg::min_s(acc_q, mem_rdata_i) : acc_q;

  assign res_o.status = sts_q;
  assign res_o.value  = acc_q;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pend_d      = pend_q;
    k_d         = k_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    cur_d       = cur_q;
    sts_d       = sts_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = k_q;
    mem_wdata_o = cur_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = k_sib;
    in_i.ready  = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      rmst_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '0;
        if (clr_q == LastAddr) begin
          state_d = rmst_pkg::ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      rmst_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) begin
          pend_d = 1'b0;
          if (in_i.action == rmst_pkg::ActQuery) begin
            if (in_i.range_end > leaf_count_i) begin
              sts_d   = rmst_pkg::StOutOfRange;
              acc_d   = '0;
              state_d = rmst_pkg::ST_PUT;
            end else if (in_i.range_start >= in_i.range_end) begin
              sts_d   = rmst_pkg::StQryOk;
              acc_d   = rmst_pkg::EmptyMin;
              state_d = rmst_pkg::ST_PUT;
            end else begin
              sts_d   = rmst_pkg::StQryOk;
              acc_d   = rmst_pkg::EmptyMin;
              l_d     = l_sum[IW-1:0];
              r_d     = r_sum[IW-1:0];
              state_d = rmst_pkg::ST_QRY;
            end
          end else begin
            if ({1'b0, in_i.leaf_index} >= leaf_count_i) begin
              sts_d   = rmst_pkg::StOutOfRange;
              acc_d   = '0;
              state_d = rmst_pkg::ST_PUT;
            end else begin
              sts_d   = rmst_pkg::StUpdDone;
              acc_d   = '0;
              k_d     = k_sum[AW-1:0];
              cur_d   = in_i.new_value;
              state_d = rmst_pkg::ST_UPD;
            end
          end
        end
      end
      rmst_pkg::ST_UPD: begin
        mem_we_o = 1'b1;
        if (!pend_q) begin
          if (k_q == RootAddr) begin
            state_d = rmst_pkg::ST_PUT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = k_sib;
            pend_d      = 1'b1;
          end
        end else begin
          mem_waddr_o = parent;
          mem_wdata_o = upd_min;
          cur_d       = upd_min;
          k_d         = parent;
          if (parent == RootAddr) begin
            pend_d  = 1'b0;
            state_d = rmst_pkg::ST_PUT;
          end else begin
            mem_re_o    = 1'b1;
            mem_raddr_o = parent_sib;
          end
        end
      end
      rmst_pkg::ST_QRY: begin
        acc_d = acc_fold;
        if (l_q < r_q) begin
          mem_re_o = 1'b1;
          if (l_q[0]) begin
            mem_raddr_o = l_q[AW-1:0];
            if (!r_q[0]) begin
              l_d = l_inc >> 1;
              r_d = r_q >> 1;
            end else begin
              l_d = l_inc;
            end
          end else if (r_q[0]) begin
            mem_raddr_o = r_dec[AW-1:0];
            l_d         = l_q >> 1;
            r_d         = r_dec >> 1;
          end else begin
            mem_re_o = 1'b0;
            l_d      = l_q >> 1;
            r_d      = r_q >> 1;
          end
          pend_d = mem_re_o;
        end else if (pend_q) begin
          pend_d = 1'b0;
        end else begin
          state_d = rmst_pkg::ST_PUT;
        end
      end
      rmst_pkg::ST_PUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = rmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rmst_pkg::ST_IDLE;
      end
    endcase

    if (clear_i) begin
      state_d = rmst_pkg::ST_CLEAR;
      clr_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rmst_pkg::ST_CLEAR;
      clr_q   <= '0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    l_q   <= l_d;
    r_q   <= r_d;
    acc_q <= acc_d;
    cur_q <= cur_d;
    sts_q <= sts_d;
  end

endmodule

[rtl/range_minimum_segment_tree_top.sv]
// Top level of the range-minimum segment tree: leaf count register, result register,
// node store and sequencer. Depends on rmst_pkg, rmst_in_if, rmst_out_if, rmst_ram, rmst_ctrl.
//
// Keeps a bottom-up segment tree of signed 32-bit minimums in one single-port-read,
// single-port-write memory of 2*MAX_LEAVES entries. One transaction is worked at a time.
// An update does one memory read of the sibling and one write of the parent per tree
// level. A query is bounded by the single read port, which fetches at most one covering
// node per cycle. Out-of-range and empty items skip the tree and go straight to the result.
// After reset and after every write of leaf_count the tree is zeroed by a sweep over all
// 2*MAX_LEAVES entries, during which no input transaction is taken. The result register
// lets a new transaction enter while the previous result waits on the output.
module range_minimum_segment_tree_top #(
  parameter int MAX_LEAVES = rmst_pkg::MaxLeavesDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  rmst_in_if.sink                      in_i,
  rmst_out_if.source                   out_o,
  input  logic                         cfg_we_i,
  input  logic [rmst_pkg::CountW-1:0]  cfg_wdata_i
);

  localparam int AW = $clog2(2 * MAX_LEAVES);
  localparam int ResetCount = (MAX_LEAVES < 1024) ? MAX_LEAVES : 1024;

  logic [rmst_pkg::CountW-1:0] leaf_count_q, leaf_count_d;
  logic                        out_valid_q;
  rmst_pkg::res_t              out_res_q;

  logic                               res_valid, res_ready;
  rmst_pkg::res_t                     res;
  logic                               mem_we, mem_re;
  logic [AW-1:0]                      mem_waddr, mem_raddr;
  logic signed [rmst_pkg::ValueW-1:0] mem_wdata, mem_rdata;

  always_comb begin
    leaf_count_d = cfg_wdata_i;
    if (cfg_wdata_i == '0) begin
      leaf_count_d = rmst_pkg::CountW'(1);
    end else if (32'(cfg_wdata_i) > MAX_LEAVES) begin
      leaf_count_d = rmst_pkg::CountW'(MAX_LEAVES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      leaf_count_q <= rmst_pkg::CountW'(ResetCount);
    end else if (cfg_we_i) begin
      leaf_count_q <= leaf_count_d;
    end
  end

  assign res_ready = !out_valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.status    = out_res_q.status;
  assign out_o.range_min = out_res_q.value;

  rmst_ctrl #(
    .MAX_LEAVES(MAX_LEAVES),
    .AW        (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .leaf_count_i(leaf_count_q),
    .clear_i     (cfg_we_i),
    .in_i        (in_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  rmst_ram #(
    .Depth(2 * MAX_LEAVES),
    .AddrW(AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

[rtl/rmst_checker.sv]
// Port-level checks of the range-minimum segment tree, bound to the top level.
// Depends on rmst_pkg and range_minimum_segment_tree_top.
module rmst_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_i,
  input logic                               out_valid_i,
  input logic                               out_ready_i,
  input logic [rmst_pkg::StatusW-1:0]       out_status_i,
  input logic signed [rmst_pkg::ValueW-1:0] out_range_min_i,
  input logic                               cfg_we_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before its transaction completed");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while a transaction is in progress");

  a_clear_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !in_ready_i)
    else $error("input taken during the clearing sweep");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i == rmst_pkg::StUpdDone ||
                    out_status_i == rmst_pkg::StQryOk ||
                    out_status_i == rmst_pkg::StOutOfRange)
    else $error("undefined status code on the result");

  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != rmst_pkg::StQryOk |-> out_range_min_i == '0)
    else $error("nonzero minimum on an update or rejected result");

endmodule

bind range_minimum_segment_tree_top rmst_checker u_rmst_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_status_i   (out_o.status),
  .out_range_min_i(out_o.range_min),
  .cfg_we_i       (cfg_we_i)
);
